FILE: design/lfuc_pkg.sv
`timescale 1ns / 1ps

package lfuc_pkg;

   // Default geometry
   localparam int DEF_ENTRIES    = 16;
   localparam int DEF_COUNT_BITS = 16;

   // Fixed field widths
   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int TOUCH_W = 64;
   localparam int CAP_W   = 5;

   // Capacity register reset value
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request codes
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   // Value returned on a miss or for a put
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;

   // Status of one scan pass over the entries
   typedef struct packed {
      logic found;
      logic free_seen;
      logic victim_seen;
   } scan_flags_type;

endpackage

FILE: design/lfuc_scan.sv
`timescale 1ns / 1ps

module lfuc_scan #(
   parameter int ENTRIES    = lfuc_pkg::DEF_ENTRIES,
   parameter int COUNT_BITS = lfuc_pkg::DEF_COUNT_BITS,
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int NV_W      = $clog2(ENTRIES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          live,
   input  logic                          entry_vld,
   input  logic [IDX_W-1:0]              entry_idx,
   input  logic [lfuc_pkg::KEY_W-1:0]    entry_key,
   input  logic [lfuc_pkg::DATA_W-1:0]   entry_data,
   input  logic [COUNT_BITS-1:0]         entry_count,
   input  logic [lfuc_pkg::TOUCH_W-1:0]  entry_touch,
   input  logic [lfuc_pkg::KEY_W-1:0]    match_key,
   output lfuc_pkg::scan_flags_type      flags,
   output logic [IDX_W-1:0]              found_idx,
   output logic [lfuc_pkg::DATA_W-1:0]   found_data,
   output logic [COUNT_BITS-1:0]         found_count,
   output logic [IDX_W-1:0]              free_idx,
   output logic [IDX_W-1:0]              victim_idx,
   output logic [lfuc_pkg::KEY_W-1:0]    victim_key,
   output logic [NV_W-1:0]               valid_count
);

   lfuc_pkg::scan_flags_type           flags_ff;
   logic [NV_W-1:0]                    nvalid_ff;
   logic [IDX_W-1:0]                   found_idx_ff;
   logic [lfuc_pkg::DATA_W-1:0]        found_data_ff;
   logic [COUNT_BITS-1:0]              found_cnt_ff;
   logic [IDX_W-1:0]                   free_idx_ff;
   logic [IDX_W-1:0]                   vic_idx_ff;
   logic [lfuc_pkg::KEY_W-1:0]         vic_key_ff;
   logic [COUNT_BITS-1:0]              vic_cnt_ff;
   logic [lfuc_pkg::TOUCH_W-1:0]       vic_touch_ff;
   logic                               take_match;
   logic                               take_victim;

   // Pick the first matching key; pick a lower count, older touch among equals
   always_comb begin
      take_match  = !flags_ff.found && (entry_key == match_key);
      take_victim = !flags_ff.victim_seen || (entry_count < vic_cnt_ff) ||
                    ((entry_count == vic_cnt_ff) && (entry_touch < vic_touch_ff));
   end

   // Clear trackers on start, fold in one entry per live beat
   always_ff @(posedge clock) begin
      if (reset || start) begin
         flags_ff  <= '0;
         nvalid_ff <= '0;
      end else if (live) begin
         if (entry_vld) begin
            nvalid_ff <= nvalid_ff + NV_W'(1);
            if (take_match) begin
               flags_ff.found <= 1'b1;
               found_idx_ff   <= entry_idx;
               found_data_ff  <= entry_data;
               found_cnt_ff   <= entry_count;
            end
            if (take_victim) begin
               flags_ff.victim_seen <= 1'b1;
               vic_idx_ff           <= entry_idx;
               vic_key_ff           <= entry_key;
               vic_cnt_ff           <= entry_count;
               vic_touch_ff         <= entry_touch;
            end
         end else if (!flags_ff.free_seen) begin
            flags_ff.free_seen <= 1'b1;
            free_idx_ff        <= entry_idx;
         end
      end
   end

   assign flags       = flags_ff;
   assign found_idx   = found_idx_ff;
   assign found_data  = found_data_ff;
   assign found_count = found_cnt_ff;
   assign free_idx    = free_idx_ff;
   assign victim_idx  = vic_idx_ff;
   assign victim_key  = vic_key_ff;
   assign valid_count = nvalid_ff;

endmodule

FILE: design/lfu_cache.sv
`timescale 1ns / 1ps

// Key-value cache with least-frequently-used replacement, oldest touch first
// among entries of equal use count.
// Request channel (req_*): one get or put per beat, valid/stall handshake.
// Response channel (rsp_*): exactly one beat per request, in request order.
// Config channel (csr_*): valid/ready write of the active capacity; always
// ready. The user must write it only while no request is in flight; the
// block itself does not enforce this. Each request walks the entry memory
// one row per cycle through its single read port, passes a drain state,
// then decides and writes back in the decide state. The next request is
// accepted only after the previous one has left the decide state.
// The response sits in an output register: while the receiver stalls it
// holds, and a new request may be accepted and scanned meanwhile; the block
// waits in its write-back cycle until the register frees up.
// Reset (synchronous) clears all valid marks, the touch clock and the
// response valid flag, and sets the capacity to 16. No clearing pass is needed.

module lfu_cache #(
   parameter int ENTRIES    = lfuc_pkg::DEF_ENTRIES,
   parameter int COUNT_BITS = lfuc_pkg::DEF_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic signed [lfuc_pkg::KEY_W-1:0]  req_lookup_key,
   input  logic signed [lfuc_pkg::DATA_W-1:0] req_store_value,
   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic signed [lfuc_pkg::DATA_W-1:0] rsp_read_value,
   output logic                               rsp_evicted,
   output logic signed [lfuc_pkg::KEY_W-1:0]  rsp_evicted_key,
   // Config channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lfuc_pkg::CAP_W-1:0]         csr_active_capacity
);

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int NV_W    = $clog2(ENTRIES + 1);
   localparam int CMP_W   = ((NV_W > lfuc_pkg::CAP_W) ? NV_W : lfuc_pkg::CAP_W) + 1;
   localparam int KEY_LO  = 0;
   localparam int DATA_LO = KEY_LO + lfuc_pkg::KEY_W;
   localparam int CNT_LO  = DATA_LO + lfuc_pkg::DATA_W;
   localparam int TCH_LO  = CNT_LO + COUNT_BITS;
   localparam int ROW_W   = TCH_LO + lfuc_pkg::TOUCH_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   state_type                        state_ff;
   logic [lfuc_pkg::CAP_W-1:0]       cap_ff;
   logic [ENTRIES-1:0]               valid_ff;
   logic [lfuc_pkg::TOUCH_W-1:0]     clock_ff;
   logic [IDX_W-1:0]                 scan_idx_ff;
   logic                             chk_live_ff;
   logic                             chk_vld_ff;
   logic [IDX_W-1:0]                 chk_idx_ff;
   logic                             op_ff;
   logic [lfuc_pkg::KEY_W-1:0]       key_ff;
   logic [lfuc_pkg::DATA_W-1:0]      val_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_hit_ff;
   logic [lfuc_pkg::DATA_W-1:0]      rsp_value_ff;
   logic                             rsp_ev_ff;
   logic [lfuc_pkg::KEY_W-1:0]       rsp_ev_key_ff;

   // Entry memory: key, data, use count and touch time per row
   logic [ROW_W-1:0]                 mem [ENTRIES];
   logic [ROW_W-1:0]                 rdata_ff;

   lfuc_pkg::scan_flags_type         flags;
   logic [IDX_W-1:0]                 found_idx;
   logic [lfuc_pkg::DATA_W-1:0]      found_data;
   logic [COUNT_BITS-1:0]            found_count;
   logic [IDX_W-1:0]                 free_idx;
   logic [IDX_W-1:0]                 victim_idx;
   logic [lfuc_pkg::KEY_W-1:0]       victim_key;
   logic [NV_W-1:0]                  valid_count;

   logic                             req_take;
   logic                             rsp_free;
   logic                             commit;
   logic                             is_put;
   logic                             cap_zero;
   logic                             full;
   logic [COUNT_BITS-1:0]            bumped;
   logic                             wr_en;
   logic                             wr_new;
   logic [IDX_W-1:0]                 wr_idx;
   logic [lfuc_pkg::DATA_W-1:0]      wr_data;
   logic [COUNT_BITS-1:0]            wr_count;
   logic                             ev;
   logic [lfuc_pkg::DATA_W-1:0]      read_value;

   // Handshakes
   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_DECIDE) && rsp_free;
   assign csr_ready = 1'b1;

   lfuc_scan #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (req_take),
      .live        (chk_live_ff),
      .entry_vld   (chk_vld_ff),
      .entry_idx   (chk_idx_ff),
      .entry_key   (rdata_ff[KEY_LO +: lfuc_pkg::KEY_W]),
      .entry_data  (rdata_ff[DATA_LO +: lfuc_pkg::DATA_W]),
      .entry_count (rdata_ff[CNT_LO +: COUNT_BITS]),
      .entry_touch (rdata_ff[TCH_LO +: lfuc_pkg::TOUCH_W]),
      .match_key   (key_ff),
      .flags       (flags),
      .found_idx   (found_idx),
      .found_data  (found_data),
      .found_count (found_count),
      .free_idx    (free_idx),
      .victim_idx  (victim_idx),
      .victim_key  (victim_key),
      .valid_count (valid_count)
   );

   // Decide the write-back from the scan result
   always_comb begin
      is_put   = (op_ff == lfuc_pkg::REQ_PUT);
      cap_zero = (cap_ff == '0);
      full     = (CMP_W'(valid_count) >= CMP_W'(cap_ff)) ||
                 (valid_count == NV_W'(ENTRIES));
      bumped   = (found_count == '1) ? found_count : found_count + COUNT_BITS'(1);
      wr_en    = 1'b0;
      wr_new   = 1'b0;
      wr_idx   = found_idx;
      wr_data  = found_data;
      wr_count = bumped;
      ev       = 1'b0;
      read_value = lfuc_pkg::MISS_VALUE;
      if (!is_put) begin
         if (flags.found) begin
            wr_en      = 1'b1;
            read_value = found_data;
         end
      end else if (!cap_zero) begin
         if (flags.found) begin
            wr_en   = 1'b1;
            wr_data = val_ff;
         end else begin
            wr_data  = val_ff;
            wr_count = COUNT_BITS'(1);
            if (full && flags.victim_seen) begin
               ev     = 1'b1;
               wr_en  = 1'b1;
               wr_new = 1'b1;
               wr_idx = victim_idx;
            end else if (flags.free_seen) begin
               wr_en  = 1'b1;
               wr_new = 1'b1;
               wr_idx = free_idx;
            end
         end
      end
   end

   // Read the row at the scan index every cycle; write back only in the decide
   // state, while no scanned read data is in use
   always_ff @(posedge clock) begin
      if (commit && wr_en) begin
         mem[wr_idx] <= {clock_ff, wr_count, wr_data, key_ff};
      end
      rdata_ff <= mem[scan_idx_ff];
   end

   // Sequencer, bookkeeping and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= lfuc_pkg::CAP_RESET;
         valid_ff     <= '0;
         clock_ff     <= '0;
         scan_idx_ff  <= '0;
         chk_live_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_active_capacity;
         end

         // Track the row whose read data lands next cycle
         chk_live_ff <= (state_ff == ST_SCAN);
         chk_idx_ff  <= scan_idx_ff;
         chk_vld_ff  <= valid_ff[scan_idx_ff];

         // Drop the response once taken, unless a new one replaces it
         if (rsp_valid_ff && !rsp_stall && !commit) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  op_ff       <= req_type;
                  key_ff      <= req_lookup_key;
                  val_ff      <= req_store_value;
                  scan_idx_ff <= '0;
                  state_ff    <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_idx_ff == IDX_W'(ENTRIES - 1)) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  scan_idx_ff <= scan_idx_ff + IDX_W'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (rsp_free) begin
                  if (wr_en) begin
                     clock_ff <= clock_ff + lfuc_pkg::TOUCH_W'(1);
                  end
                  if (wr_new) begin
                     valid_ff[wr_idx] <= 1'b1;
                  end
                  rsp_valid_ff  <= 1'b1;
                  rsp_hit_ff    <= flags.found;
                  rsp_value_ff  <= read_value;
                  rsp_ev_ff     <= ev;
                  rsp_ev_key_ff <= ev ? victim_key : '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_evicted     = rsp_ev_ff;
   assign rsp_evicted_key = rsp_ev_key_ff;

endmodule
